@@ rtl/core/arcs_pkg.sv @@
// ----------------------------------------------------------------------------
// arcs_pkg
// Shared constants for the anti-aliased round-cap sprite core.
// ----------------------------------------------------------------------------
package arcs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAP_DIAM   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR = 1'd1;

  localparam logic [7:0]  CAP_DIAM_RST   = 8'd16;
  localparam logic [31:0] BASE_COLOR_RST = 32'hFFFF_FFFF;

  localparam logic [16:0] COV_ONE    = 17'h1_0000;
  localparam logic [24:0] ROUND_HALF = 25'h000_8000;
  localparam logic [31:0] QUARTER_Q32 = 32'h4000_0000;

endpackage

@@ rtl/core/arcs_fifo.sv @@
// ----------------------------------------------------------------------------
// arcs_fifo
// Two-entry queue that decouples the classifier from the evaluation pipeline.
// ----------------------------------------------------------------------------
module arcs_fifo #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     push_data_i,
  input  logic pop_i,
  output T     head_o,
  output logic empty_o,
  output logic full_o
);

  T           mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/arcs_front.sv @@
// ----------------------------------------------------------------------------
// arcs_front
// Classifies a pixel: sprite region check, top-half row, the two candidate
// boundary rows, and the radicands of their boundary square roots.
// ----------------------------------------------------------------------------
module arcs_front #(
  parameter int MAX_RADIUS = 64
) (
  input  logic [7:0]  cap_diam_i,
  input  logic [7:0]  pixel_row_i,
  input  logic [6:0]  pixel_col_i,
  output logic [1+7+2*$clog2(MAX_RADIUS+1)+2+4*($clog2(MAX_RADIUS+1)+16)-1:0] item_o
);

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int SW = RW + 16;
  localparam int NW = (RW + 2 > 9) ? RW + 2 : 9;
  localparam int TW = 2 * RW;

  typedef struct packed {
    logic              pix_ok;
    logic [6:0]        col;
    logic [RW-1:0]     k1;
    logic [RW-1:0]     k2;
    logic              ext_en;
    logic              k2_ge;
    logic [2*SW-1:0]   d1;
    logic [2*SW-1:0]   d2;
  } item_t;

  localparam logic [NW-1:0] SW_MAX = NW'(2 * MAX_RADIUS);

  logic [NW-1:0] sw_raw, sw_c, r, w, h, row, col, src, k2n, last_row;
  logic [RW-1:0] rr, m1, m2;
  logic [TW-1:0] t1, t2;
  item_t         item;

  always_comb begin
    sw_raw   = NW'(cap_diam_i);
    sw_c     = (sw_raw > SW_MAX) ? SW_MAX : sw_raw;
    r        = sw_c >> 1;
    w        = r << 1;
    h        = sw_c + NW'(2);
    last_row = h - NW'(1);
    row      = NW'(pixel_row_i);
    col      = NW'(pixel_col_i);
    src      = (row <= r) ? row : (last_row - row);
    k2n      = (col < r) ? col : (w - NW'(1) - col);
    rr       = r[RW-1:0];
    // Distance from the disc center row, in whole rows.
    m1       = rr - src[RW-1:0];
    m2       = rr - k2n[RW-1:0] - RW'(1);
    t1       = TW'(rr) * TW'(rr) - TW'(m1) * TW'(m1) - TW'(m1);
    t2       = TW'(rr) * TW'(rr) - TW'(m2) * TW'(m2) - TW'(m2);

    item.pix_ok = (r != '0) && (col < w) && (row != '0) && (row < last_row)
                  && ((row <= r) || (row >= last_row - r));
    item.col    = pixel_col_i;
    item.k1     = RW'(src - NW'(1));
    item.k2     = k2n[RW-1:0];
    item.ext_en = ((k2n << 1) >= (r - NW'(r[0])));
    item.k2_ge  = (k2n >= (src - NW'(1)));
    // (m + 0.5)^2 is folded in as m^2 + m + 1/4.
    item.d1     = {t1, 32'd0} - (2*SW)'(arcs_pkg::QUARTER_Q32);
    item.d2     = {t2, 32'd0} - (2*SW)'(arcs_pkg::QUARTER_Q32);
    item_o      = item;
  end

endmodule

@@ rtl/core/arcs_back.sv @@
// ----------------------------------------------------------------------------
// arcs_back
// Evaluation pipeline: two digit-by-digit square roots, one bit per stage,
// then boundary and coverage, then the output register.
// ----------------------------------------------------------------------------
module arcs_back #(
  parameter int MAX_RADIUS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  cap_diam_i,
  input  logic [31:0] base_color_i,
  input  logic        head_valid_i,
  input  logic [1+7+2*$clog2(MAX_RADIUS+1)+2+4*($clog2(MAX_RADIUS+1)+16)-1:0] head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_argb_o
);

  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int SW  = RW + 16;
  localparam int DW  = 2 * SW;
  localparam int RMW = SW + 3;
  localparam int NW  = (RW + 2 > 9) ? RW + 2 : 9;
  localparam int FB  = arcs_pkg::FRAC_BITS;

  typedef struct packed {
    logic              pix_ok;
    logic [6:0]        col;
    logic [RW-1:0]     k1;
    logic [RW-1:0]     k2;
    logic              ext_en;
    logic              k2_ge;
    logic [DW-1:0]     d1;
    logic [DW-1:0]     d2;
  } item_t;

  typedef struct packed {
    logic [DW-1:0]  d;
    logic [RMW-1:0] rem;
    logic [SW-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic              pix_ok;
    logic [6:0]        col;
    logic [RW-1:0]     k1;
    logic [RW-1:0]     k2;
    logic              ext_en;
    logic              k2_ge;
  } tag_t;

  function automatic sq_t sq_step(sq_t s);
    logic [RMW-1:0] rem_t;
    logic [RMW-1:0] trial;
    sq_t            o;
    rem_t = {s.rem[RMW-3:0], s.d[DW-1 -: 2]};
    trial = RMW'({s.root, 2'b01});
    o.d   = s.d << 2;
    if (rem_t >= trial) begin
      o.rem  = rem_t - trial;
      o.root = {s.root[SW-2:0], 1'b1};
    end else begin
      o.rem  = rem_t;
      o.root = {s.root[SW-2:0], 1'b0};
    end
    return o;
  endfunction

  item_t head;
  logic  adv;
  logic  out_valid_q;
  logic [31:0] argb_q, argb_d;

  logic  vld_q  [SW];
  tag_t  tag_q  [SW];
  sq_t   sa_q   [SW];
  sq_t   sb_q   [SW];

  assign head        = head_i;
  assign adv         = !out_valid_q || !out_stall_i;
  assign pop_o       = adv && head_valid_i;
  assign out_valid_o = out_valid_q;
  assign pixel_argb_o = argb_q;

  tag_t head_tag;
  sq_t  head_sa, head_sb;

  always_comb begin
    head_tag.pix_ok = head.pix_ok;
    head_tag.col    = head.col;
    head_tag.k1     = head.k1;
    head_tag.k2     = head.k2;
    head_tag.ext_en = head.ext_en;
    head_tag.k2_ge  = head.k2_ge;
    head_sa.d       = head.d1;
    head_sa.rem     = '0;
    head_sa.root    = '0;
    head_sb.d       = head.d2;
    head_sb.rem     = '0;
    head_sb.root    = '0;
  end

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (adv) begin
        vld_q[j] <= (j == 0) ? pop_o : vld_q[(j == 0) ? 0 : j-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (j == 0) begin
          tag_q[j] <= head_tag;
          sa_q[j]  <= sq_step(head_sa);
          sb_q[j]  <= sq_step(head_sb);
        end else begin
          tag_q[j] <= tag_q[(j == 0) ? 0 : j-1];
          sa_q[j]  <= sq_step(sa_q[(j == 0) ? 0 : j-1]);
          sb_q[j]  <= sq_step(sb_q[(j == 0) ? 0 : j-1]);
        end
      end
    end
  end

  // Boundary stage: round the root to nearest, then b = r - sqrt.
  logic [NW-1:0] sw_raw, sw_c, r, w;
  logic [SW:0]   s1, s2;
  logic [SW-1:0] b1_d, b2_d, r_q16;
  logic          vld_b_q;
  tag_t          tag_b_q;
  logic [SW-1:0] b1_q, b2_q;

  always_comb begin
    sw_raw = NW'(cap_diam_i);
    sw_c   = (sw_raw > NW'(2 * MAX_RADIUS)) ? NW'(2 * MAX_RADIUS) : sw_raw;
    r      = sw_c >> 1;
    w      = r << 1;
    r_q16  = {r[RW-1:0], {FB{1'b0}}};
    s1     = (SW+1)'(sa_q[SW-1].root)
             + (SW+1)'(sa_q[SW-1].rem > RMW'(sa_q[SW-1].root));
    s2     = (SW+1)'(sb_q[SW-1].root)
             + (SW+1)'(sb_q[SW-1].rem > RMW'(sb_q[SW-1].root));
    b1_d   = r_q16 - s1[SW-1:0];
    b2_d   = r_q16 - s2[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (adv) begin
      vld_b_q <= vld_q[SW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_b_q <= tag_q[SW-1];
      b1_q    <= b1_d;
      b2_q    <= b2_d;
    end
  end

  // Pixel composition.
  logic [NW-1:0] right1, right2, colw, k1w;
  logic [15:0]   frac1, frac2;
  logic [16:0]   cov1, cov2;
  logic [24:0]   prod1, prod2;
  logic [31:0]   edge1_c, edge2_c, row_v;
  logic          fill_hit, edge_hit, row_hit, ext_hit;

  always_comb begin
    right1  = NW'(b1_q[SW-1:FB]);
    right2  = NW'(b2_q[SW-1:FB]);
    frac1   = b1_q[FB-1:0];
    frac2   = b2_q[FB-1:0];
    cov1    = (frac1 != '0) ? (arcs_pkg::COV_ONE - 17'(frac1)) : '0;
    cov2    = (frac2 != '0) ? (arcs_pkg::COV_ONE - 17'(frac2)) : '0;
    prod1   = 25'(cov1) * 25'(base_color_i[31:24]) + arcs_pkg::ROUND_HALF;
    prod2   = 25'(cov2) * 25'(base_color_i[31:24]) + arcs_pkg::ROUND_HALF;
    edge1_c = {prod1[23:16], base_color_i[23:0]};
    edge2_c = {prod2[23:16], base_color_i[23:0]};
    colw    = NW'(tag_b_q.col);
    k1w     = NW'(tag_b_q.k1);
    fill_hit = (colw >= right1 + NW'(1)) && (colw + right1 + NW'(2) <= w);
    edge_hit = (colw == right1) || (colw == w - right1 - NW'(1));
    row_hit  = fill_hit || edge_hit;
    row_v    = edge_hit ? edge1_c : (fill_hit ? base_color_i : '0);
    // Extra edge pixel on the vertical sides, placed at row floor(b)+1.
    ext_hit  = tag_b_q.ext_en && (k1w == right2);
    if (!tag_b_q.pix_ok) begin
      argb_d = '0;
    end else if (ext_hit && (tag_b_q.k2_ge || !row_hit)) begin
      argb_d = edge2_c;
    end else begin
      argb_d = row_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      argb_q <= argb_d;
    end
  end

endmodule

@@ rtl/core/antialiased_round_cap_sprite_core.sv @@
// ----------------------------------------------------------------------------
// antialiased_round_cap_sprite_core
// Per-pixel ARGB lookup of an anti-aliased round-cap disc sprite.
// ----------------------------------------------------------------------------
// The core takes one sprite coordinate per beat and returns one ARGB8888 pixel
// per beat, at a sustained rate of one pixel per clock while the output is
// not stalled. The square root pipeline resolves one root bit per stage for
// the two boundary rows a pixel depends on. A two-entry queue sits between
// the classifier and the evaluation pipeline, and the output register holds
// a stalled result while the queue takes new coordinates until it is full.
// Write the cap diameter and base_color only while no pixel is in flight.
module antialiased_round_cap_sprite_core #(
  parameter int MAX_RADIUS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [arcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_row_i,
  input  logic [6:0]  pixel_col_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_argb_o
);

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int SW = RW + 16;
  localparam int IW = 1 + 7 + 2 * RW + 2 + 4 * SW;

  typedef logic [IW-1:0] item_vec_t;

  logic [7:0]  cap_diam_q;
  logic [31:0] base_color_q;
  item_vec_t   item, head;
  logic        push, pop, empty, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_diam_q   <= arcs_pkg::CAP_DIAM_RST;
      base_color_q <= arcs_pkg::BASE_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        arcs_pkg::REG_CAP_DIAM:   cap_diam_q   <= cfg_wdata_i[7:0];
        arcs_pkg::REG_BASE_COLOR: base_color_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  arcs_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .cap_diam_i  (cap_diam_q),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .item_o      (item)
  );

  arcs_fifo #(.T(item_vec_t)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (item),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  arcs_back #(.MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_diam_i   (cap_diam_q),
    .base_color_i (base_color_q),
    .head_valid_i (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_argb_o (pixel_argb_o)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-cap sprite core: a queue-fed driver sends
// sprite coordinates under several stroke and color settings, a monitor
// compares each pixel with a local fixed-point prediction of the disc.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_RADIUS = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] row;
    logic [6:0] col;
  } coord_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [arcs_pkg::CFG_IDX_W-1:0] cfg_idx_i = arcs_pkg::REG_CAP_DIAM;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_row_i = '0;
  logic [6:0]  pixel_col_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] pixel_argb_o;

  antialiased_round_cap_sprite_core #(.MAX_RADIUS(MAX_RADIUS)) dut (.*);

  always #2 clk_i = ~clk_i;

  logic [7:0]  cur_stroke = arcs_pkg::CAP_DIAM_RST;
  logic [31:0] cur_color = arcs_pkg::BASE_COLOR_RST;
  coord_t      pending_q[$];
  logic [31:0] expected_pixels_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          drv_wait = 0;
  int          mon_wait = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v,
                                               output longint unsigned rem);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    rem = v;
    return res;
  endfunction

  // Left boundary of top-half row k, Q.16.
  function automatic longint unsigned edge_q16(longint unsigned r, longint unsigned k);
    longint unsigned m, d, s, rem;
    m = r - k - 1;
    d = ((r * r - m * m - m) << 32) - (64'd1 << 30);
    s = int_sqrt(d, rem);
    if (rem > s) s += 1;
    return (r << 16) - s;
  endfunction

  function automatic logic [31:0] sprite_pixel(coord_t c);
    longint unsigned sw, r, w, h, src, b, right, frac, cov, a, row, col;
    logic [31:0] val, edge_px;
    sw = cur_stroke;
    row = c.row;
    col = c.col;
    val = '0;
    if (sw > 2 * MAX_RADIUS) sw = 2 * MAX_RADIUS;
    r = sw / 2;
    w = 2 * r;
    h = sw + 2;
    if (r == 0 || col >= w || row == 0 || row >= h - 1) return '0;
    if (row <= r) src = row;
    else if (row >= h - 1 - r) src = h - 1 - row;
    else return '0;
    for (longint unsigned k = 0; k < r; k++) begin
      b = edge_q16(r, k);
      right = b >> 16;
      frac = b & 64'hFFFF;
      cov = (frac != 0) ? (64'h10000 - frac) : 0;
      a = (cov * cur_color[31:24] + 64'h8000) >> 16;
      edge_px = {a[7:0], cur_color[23:0]};
      if (src == k + 1) begin
        if (col >= right + 1 && col + right + 2 <= w) val = cur_color;
        if (col == right || col == w - right - 1) val = edge_px;
      end
      if (2 * k >= r - (r & 1) && src == right + 1 && (col == k || col == w - k - 1))
        val = edge_px;
    end
    return val;
  endfunction

  // Driver: one beat per accepted item, random gap before each.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_pixels_q.push_back(sprite_pixel({pixel_row_i, pixel_col_i}));
        drv_wait = $urandom_range(0, 3);
        if (pending_q.size() > 0 && drv_wait == 0) begin
          coord_t c;
          c = pending_q.pop_front();
          pixel_row_i <= c.row;
          pixel_col_i <= c.col;
        end else begin
          in_valid_i <= 1'b0;
          // This edge already counts as the first idle cycle.
          if (drv_wait > 0) drv_wait--;
        end
      end else if (!in_valid_i && pending_q.size() > 0) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else begin
          coord_t c;
          c = pending_q.pop_front();
          pixel_row_i <= c.row;
          pixel_col_i <= c.col;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel %h", pixel_argb_o);
        end else begin
          logic [31:0] exp_px;
          exp_px = expected_pixels_q.pop_front();
          if (exp_px !== pixel_argb_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected %h got %h", exp_px, pixel_argb_o);
          end
        end
      end
      if (mon_wait > 0) begin
        mon_wait--;
        out_stall_i <= 1'b1;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
      end else if (out_valid_o) begin
        mon_wait = $urandom_range(0, 3);
        out_stall_i <= (mon_wait > 0);
        if (mon_wait > 0) mon_wait--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [arcs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == arcs_pkg::REG_CAP_DIAM) cur_stroke = data[7:0];
    else cur_color = data;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_pixels_q.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Mostly coordinates inside the sprite, some beyond its bounds.
  task automatic queue_random(int n);
    coord_t c;
    int sw;
    sw = (cur_stroke > 128) ? 128 : cur_stroke;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        c.row = 8'($urandom_range(0, sw + 1));
        c.col = 7'($urandom_range(0, (sw < 2) ? 1 : (sw / 2) * 2 - 1));
      end else begin
        c.row = 8'($urandom_range(0, 255));
        c.col = 7'($urandom_range(0, 127));
      end
      pending_q.push_back(c);
    end
  endtask

  initial begin
    logic [7:0] strokes[9] = '{8'd16, 8'd2, 8'd128, 8'd7, 8'd255, 8'd1, 8'd33, 8'd0, 8'd10};
    logic [31:0] colors[9] = '{32'hFFFFFFFF, 32'h00000000, 32'h80A0B0C0, 32'h7F123456,
                               32'hFF00FF00, 32'h01ABCDEF, 32'hC3FFFFFF, 32'hFFFFFFFF,
                               32'h5A5A5AA5};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: reset settings, corners, mirror and middle rows.
    foreach (strokes[p]) begin
      if (p > 0) begin
        write_reg(arcs_pkg::REG_CAP_DIAM, {24'h0, strokes[p]});
        write_reg(arcs_pkg::REG_BASE_COLOR, colors[p]);
      end
      if (p == 0) begin
        pending_q.push_back('{8'd0, 7'd0});
        pending_q.push_back('{8'd17, 7'd15});
        pending_q.push_back('{8'd1, 7'd7});
        pending_q.push_back('{8'd8, 7'd0});
        pending_q.push_back('{8'd9, 7'd15});
        pending_q.push_back('{8'd16, 7'd16});
        pending_q.push_back('{8'd255, 7'd127});
        pending_q.push_back('{8'd129, 7'd127});
        pending_q.push_back('{8'd5, 7'd3});
        pending_q.push_back('{8'd12, 7'd12});
      end
      queue_random((p == 2 || p == 4) ? 40 : 160);
      drain();
    end
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/arcs_pkg.sv
rtl/core/arcs_fifo.sv
rtl/core/arcs_front.sv
rtl/core/arcs_back.sv
rtl/core/antialiased_round_cap_sprite_core.sv
test/tb.sv
